FILE: rtl/lsbx_pkg.sv
// shared types, constants and codes for the lsb stego bmp extractor
package lsbx_pkg;

    localparam int SIZE_WORD_BITS  = 32;
    localparam int MAGIC_MAX_CHARS = 8;
    localparam int CHAR_BITS       = 8;
    localparam int BIT_COUNT_W     = $clog2(SIZE_WORD_BITS);
    localparam int MAGIC_INDEX_W   = $clog2(MAGIC_MAX_CHARS);
    localparam int CFG_INDEX_W     = 2;

    localparam logic [15:0] HEADER_LENGTH_RESET = 16'd54;
    localparam logic [3:0]  MAGIC_LENGTH_RESET  = 4'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_WORD    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_LENGTH  = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_MAGIC     = 3'd1,
        PH_EXT_SIZE  = 3'd2,
        PH_EXT_CHAR  = 3'd3,
        PH_DATA_SIZE = 3'd4,
        PH_DATA      = 3'd5,
        PH_DONE      = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        KIND_EXT_SIZE  = 3'd0,
        KIND_EXT_CHAR  = 3'd1,
        KIND_DATA_SIZE = 3'd2,
        KIND_DATA_BYTE = 3'd3,
        KIND_MISMATCH  = 3'd4
    } result_kind_t;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       start_of_image;
    } image_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] result_value;
        logic        last_payload;
    } result_item_t;

    typedef struct packed {
        logic [15:0] header_length;
        logic [63:0] magic_word;
        logic [3:0]  magic_length;
    } cfg_t;

endpackage

FILE: rtl/lsbx_cfg.sv
// configuration register file
module lsbx_cfg
    import lsbx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEADER_LENGTH: cfg_next.header_length = cfg_data[15:0];
                REG_MAGIC_WORD:    cfg_next.magic_word    = cfg_data;
                REG_MAGIC_LENGTH:  cfg_next.magic_length  = cfg_data[3:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_length <= HEADER_LENGTH_RESET;
            cfg_reg.magic_word    <= 64'd0;
            cfg_reg.magic_length  <= MAGIC_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/lsbx_decode.sv
// single-pass decoder: header skip, bit gathering, magic check and result build
module lsbx_decode
    import lsbx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  image_item_t  item,
    input  cfg_t         cfg,
    output logic         res_valid,
    output result_item_t res_item
);

    phase_t                   phase_reg, phase_next;
    logic [15:0]              hcount_reg, hcount_next;
    logic [BIT_COUNT_W-1:0]   bcount_reg, bcount_next;
    logic [31:0]              acc_reg, acc_next;
    logic [31:0]              remain_reg, remain_next;
    logic [MAGIC_INDEX_W-1:0] midx_reg, midx_next;

    // state as seen by this byte, after an optional restart
    phase_t                   eff_phase;
    logic [15:0]              eff_hcount;
    logic [BIT_COUNT_W-1:0]   eff_bcount;
    logic [31:0]              eff_acc;
    logic [31:0]              eff_remain;
    logic [MAGIC_INDEX_W-1:0] eff_midx;

    phase_t                   work_phase;
    logic                     header_skip;
    logic                     gather_active;
    logic                     size_phase;
    logic [BIT_COUNT_W-1:0]   last_bit_idx;
    logic [31:0]              acc_bit;
    logic                     word_done;
    logic [7:0]               char_val;
    logic [7:0]               expected;
    logic                     magic_bad;
    logic [3:0]               mlen;
    logic                     midx_last;
    logic [31:0]              remain_dec;

    always_comb
    begin
        if (item.start_of_image)
        begin
            eff_phase  = PH_HEADER;
            eff_hcount = '0;
            eff_bcount = '0;
            eff_acc    = '0;
            eff_remain = '0;
            eff_midx   = '0;
        end
        else
        begin
            eff_phase  = phase_reg;
            eff_hcount = hcount_reg;
            eff_bcount = bcount_reg;
            eff_acc    = acc_reg;
            eff_remain = remain_reg;
            eff_midx   = midx_reg;
        end
    end

    // datapath shared by the next-state and output blocks
    always_comb
    begin
        header_skip   = (eff_phase == PH_HEADER) && (eff_hcount < cfg.header_length);
        work_phase    = (eff_phase == PH_HEADER) ? PH_MAGIC : eff_phase;
        gather_active = !header_skip && (work_phase != PH_DONE);
        size_phase    = (work_phase == PH_EXT_SIZE) || (work_phase == PH_DATA_SIZE);
        last_bit_idx  = size_phase ? BIT_COUNT_W'(SIZE_WORD_BITS - 1)
                                   : BIT_COUNT_W'(CHAR_BITS - 1);
        acc_bit       = eff_acc | (32'(item.image_byte[0]) << eff_bcount);
        word_done     = eff_bcount >= last_bit_idx;
        char_val      = acc_bit[7:0];
        expected      = cfg.magic_word[{eff_midx, 3'b000} +: 8];
        magic_bad     = char_val != expected;
        if (cfg.magic_length == 4'd0)
            mlen = 4'd1;
        else if (cfg.magic_length > 4'(MAGIC_MAX_CHARS))
            mlen = 4'(MAGIC_MAX_CHARS);
        else
            mlen = cfg.magic_length;
        midx_last  = (4'(eff_midx) + 4'd1) >= mlen;
        remain_dec = eff_remain - 32'd1;
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        bcount_next = bcount_reg;
        acc_next    = acc_reg;
        remain_next = remain_reg;
        midx_next   = midx_reg;
        if (accept)
        begin
            phase_next  = eff_phase;
            hcount_next = eff_hcount;
            bcount_next = eff_bcount;
            acc_next    = eff_acc;
            remain_next = eff_remain;
            midx_next   = eff_midx;
            if (header_skip)
            begin
                hcount_next = eff_hcount + 16'd1;
            end
            else if (gather_active)
            begin
                phase_next = work_phase;
                if (word_done)
                begin
                    bcount_next = '0;
                    acc_next    = '0;
                    case (work_phase)
                        PH_MAGIC:
                        begin
                            if (magic_bad)
                                phase_next = PH_DONE;
                            else if (midx_last)
                            begin
                                midx_next  = '0;
                                phase_next = PH_EXT_SIZE;
                            end
                            else
                                midx_next = eff_midx + MAGIC_INDEX_W'(1);
                        end
                        PH_EXT_SIZE:
                        begin
                            remain_next = acc_bit;
                            phase_next  = (acc_bit == 32'd0) ? PH_DATA_SIZE : PH_EXT_CHAR;
                        end
                        PH_EXT_CHAR:
                        begin
                            remain_next = remain_dec;
                            if (remain_dec == 32'd0)
                                phase_next = PH_DATA_SIZE;
                        end
                        PH_DATA_SIZE:
                        begin
                            remain_next = acc_bit;
                            phase_next  = (acc_bit == 32'd0) ? PH_DONE : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            remain_next = remain_dec;
                            if (remain_dec == 32'd0)
                                phase_next = PH_DONE;
                        end
                        default:
                            phase_next = work_phase;
                    endcase
                end
                else
                begin
                    bcount_next = eff_bcount + BIT_COUNT_W'(1);
                    acc_next    = acc_bit;
                end
            end
        end
    end

    // outputs
    always_comb
    begin
        res_valid                 = 1'b0;
        res_item.result_kind      = KIND_EXT_SIZE;
        res_item.result_value     = acc_bit;
        res_item.last_payload     = 1'b0;
        if (accept && gather_active && word_done)
        begin
            case (work_phase)
                PH_MAGIC:
                begin
                    res_valid             = magic_bad;
                    res_item.result_kind  = KIND_MISMATCH;
                    res_item.result_value = {24'd0, char_val};
                end
                PH_EXT_SIZE:
                begin
                    res_valid             = 1'b1;
                    res_item.result_kind  = KIND_EXT_SIZE;
                end
                PH_EXT_CHAR:
                begin
                    res_valid             = 1'b1;
                    res_item.result_kind  = KIND_EXT_CHAR;
                    res_item.result_value = {24'd0, char_val};
                end
                PH_DATA_SIZE:
                begin
                    res_valid             = 1'b1;
                    res_item.result_kind  = KIND_DATA_SIZE;
                    res_item.last_payload = acc_bit == 32'd0;
                end
                PH_DATA:
                begin
                    res_valid             = 1'b1;
                    res_item.result_kind  = KIND_DATA_BYTE;
                    res_item.result_value = {24'd0, char_val};
                    res_item.last_payload = remain_dec == 32'd0;
                end
                default:
                    res_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hcount_reg <= '0;
            bcount_reg <= '0;
            acc_reg    <= '0;
            remain_reg <= '0;
            midx_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            bcount_reg <= bcount_next;
            acc_reg    <= acc_next;
            remain_reg <= remain_next;
            midx_reg   <= midx_next;
        end
    end

endmodule

FILE: rtl/lsbx_outq.sv
// two-entry result queue: output register plus skid entry
module lsbx_outq
    import lsbx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_item_t push_item,
    output logic         full,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    result_item_t head_reg, head_next;
    result_item_t tail_reg, tail_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         pop;

    assign pop          = result_valid && !result_stall;
    assign result_valid = cnt_reg != 2'd0;
    assign full         = cnt_reg == 2'd2;
    assign result_item  = head_reg;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        case ({push, pop})
            2'b11:
            begin
                if (cnt_reg == 2'd2)
                begin
                    head_next = tail_reg;
                    tail_next = push_item;
                end
                else
                    head_next = push_item;
            end
            2'b10:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0)
                    head_next = push_item;
                else
                    tail_next = push_item;
            end
            2'b01:
            begin
                cnt_next  = cnt_reg - 2'd1;
                head_next = tail_reg;
            end
            default:
                cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

FILE: rtl/lsb_stego_bmp_extractor.sv
// top level of the lsb stego bmp extractor
// usage:
//  - image channel (image_valid, image_stall, image_item) takes one file byte
//    per request, from file offset 0; start_of_image marks offset 0 and
//    restarts the decoder from any phase
//  - result channel (result_valid, result_stall, result_item) gives at most one
//    result per image byte: extension size, extension chars, payload size,
//    payload bytes (last one marked) or a magic mismatch
//  - cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes header_length,
//    magic_word and magic_length; cfg_ready is always high, write only when idle
//  - throughput: one image byte per cycle while the result queue has a free entry;
//    all decoding for a byte is a single pass through the decoder into the result queue
//  - a result is registered in the result queue when the byte that completes it
//    is accepted, and shows on the result port once all results ahead are taken
//  - the result queue holds two entries: image_stall rises only when both
//    are occupied, so bytes keep flowing while one result waits
//  - reset: configuration returns to header_length 54, magic_word 0,
//    magic_length 2; decoder sits in header skip; queue is empty
module lsb_stego_bmp_extractor
    import lsbx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   image_valid,
    output logic                   image_stall,
    input  image_item_t            image_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_item_t           result_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    cfg_t         cfg;
    logic         accept;
    logic         res_valid;
    result_item_t res_item;
    logic         q_full;

    // a byte is taken whenever the result queue has a free entry
    assign image_stall = q_full;
    assign accept      = image_valid && !q_full;

    lsbx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // header skip, lsb gathering, magic compare, size and char decode
    lsbx_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (image_item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // output register with skid entry
    lsbx_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (res_valid),
        .push_item    (res_item),
        .full         (q_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

FILE: rtl/lsbx_checker.sv
// port-level checker for the lsb stego bmp extractor, with its bind
module lsbx_checker
    import lsbx_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         image_valid,
    input logic         image_stall,
    input logic         result_valid,
    input logic         result_stall,
    input result_item_t result_item
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("stalled result changed");

    // no result appears without an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && !(image_valid && !image_stall) |=> !result_valid)
        else $error("result without accepted byte");

    // input stall only follows a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(image_stall) |-> $past(result_valid && result_stall))
        else $error("image stall without result backpressure");

    // input stall implies a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        image_stall |-> result_valid)
        else $error("image stall with empty result port");

endmodule

bind lsb_stego_bmp_extractor lsbx_checker u_lsbx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_valid  (image_valid),
    .image_stall  (image_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);

FILE: sim/tb_top.sv
// self-checking bench for the lsb stego bmp extractor, checked against an in-bench decoder
module tb_top;
    import lsbx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run ends here whatever happens
    localparam int CYCLE_LIMIT = 1_000_000;
    // extra cycles waited after the last result
    localparam int TAIL_CYCLES = 4;
    // items per random phase, eight phases give the bulk of the run
    localparam int PHASE_ITEMS = 40;
    // bytes sent under the longest header, all of them still header
    localparam int LONG_HDR_SENT = 48;
    // longest chars and bytes actually sent for a size word; bigger sizes get cut off
    localparam int MAX_EXT_SENT  = 24;
    localparam int MAX_DATA_SENT = 40;
    // the cfg index that has no register behind it
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // clock, reset and all block inputs start at known values
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   image_valid  = 1'b0;
    logic                   image_stall;
    image_item_t            image_item   = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_item_t           result_item;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [63:0]            cfg_data     = '0;

    // bench copy of the configuration registers, reset values as in the block
    logic [15:0] hdr_len_cfg = HEADER_LENGTH_RESET;
    logic [63:0] magic_cfg   = '0;
    logic [3:0]  mlen_cfg    = MAGIC_LENGTH_RESET;

    // bench copy of the decoder state
    phase_t      dec_phase = PH_HEADER;
    logic [15:0] hdr_count = '0;
    logic [4:0]  bit_cnt   = '0;
    logic [31:0] bit_acc   = '0;
    logic [31:0] remaining = '0;
    logic [2:0]  magic_idx = '0;

    // image requests waiting to be driven, and decoded results waiting to come out
    image_item_t  image_bytes_q[$];
    result_item_t decoded_q[$];
    // one file is built here first so it can be cut short
    image_item_t  file_bytes[$];
    logic         next_start;

    // idling, in percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // bookkeeping
    int cycle_count     = 0;
    int error_count     = 0;
    int stim_items      = 0;
    int files_queued    = 0;
    int bytes_accepted  = 0;
    int results_checked = 0;
    int mismatches_seen = 0;
    int reg_writes      = 0;

    // driver and monitor scratch
    bit           sent;
    result_item_t predicted;
    result_item_t oldest;

    lsb_stego_bmp_extractor DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_valid  (image_valid),
        .image_stall  (image_stall),
        .image_item   (image_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------

    // magic length as the decoder uses it: 0 counts as 1, above the max as the max
    function automatic int magic_chars();
        if (mlen_cfg == 4'd0)
            return 1;
        else if (int'(mlen_cfg) > MAGIC_MAX_CHARS)
            return MAGIC_MAX_CHARS;
        else
            return int'(mlen_cfg);
    endfunction

    // a start byte throws away everything gathered so far
    function automatic void clear_decoder();
        dec_phase = PH_HEADER;
        hdr_count = '0;
        bit_cnt   = '0;
        bit_acc   = '0;
        remaining = '0;
        magic_idx = '0;
    endfunction

    // shift one carrier bit in, lsb first; high once n bits are in
    function automatic bit gather_bit(input logic b, input int n, output logic [31:0] word);
        bit done;
        bit_acc = bit_acc | ({31'd0, b} << bit_cnt);
        word    = bit_acc;
        done    = (int'(bit_cnt) + 1 >= n);
        if (done)
        begin
            bit_acc = '0;
            bit_cnt = '0;
        end
        else
            bit_cnt = bit_cnt + 5'd1;
        return done;
    endfunction

    // one image byte through the decoder; high when it completes a result
    function automatic bit decode_byte(input image_item_t it, output result_item_t res);
        logic [31:0] word;
        bit          got;
        got  = 1'b0;
        res  = '0;
        word = '0;
        if (it.start_of_image)
            clear_decoder();
        if (dec_phase == PH_HEADER && hdr_count < hdr_len_cfg)
            hdr_count = hdr_count + 16'd1;
        else
        begin
            if (dec_phase == PH_HEADER)
                dec_phase = PH_MAGIC;
            case (dec_phase)
                PH_MAGIC:
                    if (gather_bit(it.image_byte[0], CHAR_BITS, word))
                    begin
                        if (word[7:0] != magic_cfg[{magic_idx, 3'b000} +: 8])
                        begin
                            // wrong magic char: report it and sit idle
                            dec_phase        = PH_DONE;
                            res.result_kind  = KIND_MISMATCH;
                            res.result_value = {24'd0, word[7:0]};
                            got              = 1'b1;
                        end
                        else if (int'(magic_idx) + 1 >= magic_chars())
                        begin
                            magic_idx = '0;
                            dec_phase = PH_EXT_SIZE;
                        end
                        else
                            magic_idx = magic_idx + 3'd1;
                    end
                PH_EXT_SIZE:
                    if (gather_bit(it.image_byte[0], SIZE_WORD_BITS, word))
                    begin
                        remaining        = word;
                        dec_phase        = (word == 32'd0) ? PH_DATA_SIZE : PH_EXT_CHAR;
                        res.result_kind  = KIND_EXT_SIZE;
                        res.result_value = word;
                        got              = 1'b1;
                    end
                PH_EXT_CHAR:
                    if (gather_bit(it.image_byte[0], CHAR_BITS, word))
                    begin
                        remaining = remaining - 32'd1;
                        if (remaining == 32'd0)
                            dec_phase = PH_DATA_SIZE;
                        res.result_kind  = KIND_EXT_CHAR;
                        res.result_value = {24'd0, word[7:0]};
                        got              = 1'b1;
                    end
                PH_DATA_SIZE:
                    if (gather_bit(it.image_byte[0], SIZE_WORD_BITS, word))
                    begin
                        // an empty payload ends the file on the size itself
                        remaining        = word;
                        dec_phase        = (word == 32'd0) ? PH_DONE : PH_DATA;
                        res.result_kind  = KIND_DATA_SIZE;
                        res.result_value = word;
                        res.last_payload = (word == 32'd0);
                        got              = 1'b1;
                    end
                PH_DATA:
                    if (gather_bit(it.image_byte[0], CHAR_BITS, word))
                    begin
                        remaining = remaining - 32'd1;
                        if (remaining == 32'd0)
                        begin
                            dec_phase        = PH_DONE;
                            res.last_payload = 1'b1;
                        end
                        res.result_kind  = KIND_DATA_BYTE;
                        res.result_value = {24'd0, word[7:0]};
                        got              = 1'b1;
                    end
                default:
                    ;
            endcase
        end
        return got;
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    // the first byte of a file carries the start flag if asked for
    task automatic push_byte(input logic [7:0] value);
        image_item_t it;
        it.image_byte     = value;
        it.start_of_image = next_start;
        next_start        = 1'b0;
        file_bytes.push_back(it);
    endtask

    // n carrier bytes, lsb of the word first, random upper bits
    task automatic push_bits(input logic [31:0] value, input int n);
        logic [7:0] carrier;
        for (int i = 0; i < n; i++)
        begin
            carrier    = 8'($urandom_range(255));
            carrier[0] = value[i];
            push_byte(carrier);
        end
    endtask

    // one stego file for the current settings; bad_pos >= 0 corrupts that magic char,
    // cut drops a random tail so the next start lands mid-file
    task automatic queue_file(input int hdr, input bit with_start, input int bad_pos,
                              input logic [31:0] ext_size, input logic [31:0] data_size,
                              input bit cut);
        int         keep;
        logic [7:0] ch;
        file_bytes.delete();
        next_start = with_start;
        repeat (hdr)
            push_byte(8'($urandom_range(255)));
        for (int i = 0; i < magic_chars() && (bad_pos < 0 || i <= bad_pos); i++)
        begin
            ch = magic_cfg[8*i +: 8];
            if (i == bad_pos)
                ch = ch ^ (8'd1 << $urandom_range(7));
            push_bits({24'd0, ch}, CHAR_BITS);
        end
        if (bad_pos >= 0)
            // decoder is done after the mismatch, these go nowhere
            repeat ($urandom_range(4))
                push_byte(8'($urandom_range(255)));
        else
        begin
            push_bits(ext_size, SIZE_WORD_BITS);
            repeat ((ext_size > MAX_EXT_SENT) ? MAX_EXT_SENT : ext_size)
                push_bits($urandom_range(255), CHAR_BITS);
            push_bits(data_size, SIZE_WORD_BITS);
            repeat ((data_size > MAX_DATA_SENT) ? MAX_DATA_SENT : data_size)
                push_bits($urandom_range(255), CHAR_BITS);
            repeat ($urandom_range(3))
                push_byte(8'($urandom_range(255)));
        end
        keep = cut ? $urandom_range(file_bytes.size(), 1) : file_bytes.size();
        for (int j = 0; j < keep; j++)
            image_bytes_q.push_back(file_bytes[j]);
        stim_items   += keep;
        files_queued += 1;
    endtask

    // mostly clean files with random content, the rest broken or plain noise
    task automatic random_file();
        int          pick;
        logic [31:0] ext_size;
        logic [31:0] data_size;
        image_item_t it;
        pick      = $urandom_range(99);
        ext_size  = $urandom_range(4);
        data_size = $urandom_range(12);
        // huge sizes reach the high bits of the size words; the next start cuts them off
        if (pick < 6)
            ext_size = $urandom;
        else if (pick < 12)
            data_size = $urandom;
        if (pick >= 70 && pick < 82)
            queue_file(int'(hdr_len_cfg), 1'b1, $urandom_range(magic_chars() - 1), ext_size,
                       data_size, 1'b0);
        else if (pick >= 82 && pick < 94)
            queue_file(int'(hdr_len_cfg), 1'b1, -1, ext_size, data_size, 1'b1);
        else if (pick >= 94)
        begin
            // noise with stray start flags
            repeat ($urandom_range(24, 1))
            begin
                it.image_byte     = 8'($urandom_range(255));
                it.start_of_image = ($urandom_range(7) == 0);
                image_bytes_q.push_back(it);
                stim_items += 1;
            end
        end
        else
            queue_file(int'(hdr_len_cfg), ($urandom_range(31) != 0), -1, ext_size, data_size,
                       1'b0);
    endtask

    // ------------------------------------------------------------------
    // checking and sequencing helpers
    // ------------------------------------------------------------------

    // one line per error, and the count
    task automatic report_mismatch(input string what);
        error_count += 1;
        $display("error at cycle %0d: %s", cycle_count, what);
    endtask

    // register write through the cfg channel; bench copy follows at the same edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HEADER_LENGTH: hdr_len_cfg = value[15:0];
            REG_MAGIC_WORD:    magic_cfg   = value;
            REG_MAGIC_LENGTH:  mlen_cfg    = value[3:0];
            default:           ;
        endcase
        reg_writes += 1;
    endtask

    // sampled on the falling edge so driver updates have settled;
    // the tail covers bytes still inside the block that give no result
    task automatic wait_drained();
        do
            @(negedge clk);
        while (image_bytes_q.size() != 0 || image_valid || decoded_q.size() != 0);
        repeat (TAIL_CYCLES)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // image driver: holds a request until accepted, then maybe takes a gap
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            sent = image_valid && !image_stall;
            if (sent)
            begin
                bytes_accepted += 1;
                if (decode_byte(image_item, predicted))
                    decoded_q.push_back(predicted);
            end
            // valid stays up across back-to-back requests, never dropped on a stall
            if (!image_valid || sent)
            begin
                if (image_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    image_item  <= image_bytes_q.pop_front();
                    image_valid <= 1'b1;
                end
                else
                    image_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                results_checked += 1;
                if (result_item.result_kind == KIND_MISMATCH)
                    mismatches_seen += 1;
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d value %h",
                                              result_item.result_kind,
                                              result_item.result_value));
                else
                begin
                    oldest = decoded_q.pop_front();
                    if (result_item.result_kind !== oldest.result_kind)
                        report_mismatch($sformatf("result_kind %0d, want %0d",
                                                  result_item.result_kind,
                                                  oldest.result_kind));
                    if (result_item.result_value !== oldest.result_value)
                        report_mismatch($sformatf("result_value %h, want %h (kind %0d)",
                                                  result_item.result_value,
                                                  oldest.result_value, oldest.result_kind));
                    if (result_item.last_payload !== oldest.last_payload)
                        report_mismatch($sformatf("last_payload %b, want %b (kind %0d)",
                                                  result_item.last_payload,
                                                  oldest.last_payload, oldest.result_kind));
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count += 1;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 decoded_q.size());
        $display("lsb_stego_bmp_extractor regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int send_modes[4];
        int recv_modes[4];
        int mlen_choices[10];
        int phase_start;
        bit paused;
        logic [63:0] magic_pick;
        image_item_t long_item;

        // idle modes: none, sender, receiver, both
        send_modes   = '{0, 86, 0, 12};
        recv_modes   = '{0, 0, 86, 12};
        // includes 0 and 15, which the decoder clamps
        mlen_choices = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 15};
        paused       = 1'b0;

        // single reset at the start
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: header 54, magic 0, two magic chars
        // no start flag on the first file, empty extension, empty payload
        queue_file(54, 1'b0, -1, 32'd0, 32'd0, 1'b0);
        // one extension char, one payload byte marked last
        queue_file(54, 1'b1, -1, 32'd1, 32'd1, 1'b0);
        wait_drained();

        // no header, all-ones magic, full magic length; the spare index goes nowhere
        write_reg(REG_HEADER_LENGTH, 64'd0);
        write_reg(REG_MAGIC_WORD, '1);
        write_reg(REG_MAGIC_LENGTH, 64'd8);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        queue_file(0, 1'b1, -1, 32'd3, 32'd5, 1'b0);
        // mismatch on the first and on the last magic char
        queue_file(0, 1'b1, 0, 32'd0, 32'd0, 1'b0);
        queue_file(0, 1'b1, 7, 32'd0, 32'd0, 1'b0);
        // restart in the middle of a file, then a clean one
        queue_file(0, 1'b1, -1, 32'd2, 32'd6, 1'b1);
        queue_file(0, 1'b1, -1, 32'd0, 32'd2, 1'b0);

        // random phases, two settings per idle mode
        for (int m = 0; m < 4; m++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                wait_drained();
                case ($urandom_range(3))
                    0:       magic_pick = '0;
                    1:       magic_pick = '1;
                    default: magic_pick = {$urandom, $urandom};
                endcase
                write_reg(REG_HEADER_LENGTH, 64'($urandom_range(12)));
                write_reg(REG_MAGIC_WORD, magic_pick);
                write_reg(REG_MAGIC_LENGTH, 64'(mlen_choices[$urandom_range(9)]));
                send_idle_pct  = send_modes[m];
                recv_stall_pct = recv_modes[m];
                phase_start    = stim_items;
                while (stim_items - phase_start < PHASE_ITEMS)
                begin
                    // once, halfway through: sender holds off until all results are out
                    if (!paused && stim_items - phase_start >= PHASE_ITEMS / 2)
                    begin
                        wait_drained();
                        paused = 1'b1;
                    end
                    random_file();
                end
            end
        end

        // longest header, no idling: a short file stays inside the header, nothing comes out
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(REG_HEADER_LENGTH, 64'd65535);
        for (int j = 0; j < LONG_HDR_SENT; j++)
        begin
            long_item.image_byte     = 8'($urandom_range(255));
            long_item.start_of_image = (j == 0);
            image_bytes_q.push_back(long_item);
        end
        stim_items   += LONG_HDR_SENT;
        files_queued += 1;

        // everything out, then the latency tail
        wait_drained();

        $display("sent %0d image bytes in %0d files, checked %0d results (%0d magic mismatches)",
                 bytes_accepted, files_queued, results_checked, mismatches_seen);
        $display("%0d register writes over header lengths 0..65535 and four idle patterns",
                 reg_writes);
        if (error_count == 0)
            $display("lsb_stego_bmp_extractor regression: pass");
        else
            $display("lsb_stego_bmp_extractor regression: fail");
        $finish;
    end

endmodule
